>>> rtl/core/ldrlux_pkg.sv
// Shared types, widths and constants for the LDR lux table interpolator.
package ldrlux_pkg;

    localparam int TABLE_DEPTH_DEF = 512;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int IDX_IN_W  = 9;
    localparam int RES_W     = 26;
    localparam int LUX_IN_W  = 16;
    localparam int ADC_W     = 12;
    localparam int LUX_OUT_W = 24;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 56;

    localparam int D_W       = RES_W + 1;
    localparam int DL_W      = LUX_IN_W + 1;
    localparam int SMAG_W    = 43;
    localparam int ALU_W     = 48;
    localparam int MUL_STEPS = DL_W;

    localparam logic [RES_W-1:0]     RES_SCALE     = 26'd10000;
    localparam logic [RES_W-1:0]     RES_MAX       = 26'h3FFFFFF;
    localparam logic [ADC_W-1:0]     ADC_FULL      = 12'd4095;
    localparam logic [IDX_IN_W-1:0]  LAST_IDX_RST  = 9'd452;
    localparam logic [63:0]          NOT_FOUND_LUX = 64'd1001;
    localparam logic [LUX_OUT_W-1:0] LUX_MAX       = 24'hFFFFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDIV,
        ST_SCAN_START,
        ST_SCAN,
        ST_LOAD_LO,
        ST_SUB_RR,
        ST_SUB_L,
        ST_MUL_A,
        ST_MUL_B,
        ST_SIGN,
        ST_NEG_S,
        ST_NEG_D,
        ST_DIV_LOAD,
        ST_DIV,
        ST_OUT
    } state_t;

    function automatic logic [LUX_OUT_W-1:0] sat_lux(input logic [63:0] v);
        logic [LUX_OUT_W-1:0] r;
        if (v > 64'(LUX_MAX)) begin
            r = LUX_MAX;
        end else begin
            r = v[LUX_OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/ldr_lux_table_interpolator_core.sv
// Top level: table load, divider resistance, downward scan and interpolation sequencer.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------------------
//  s_       | in  | s_tvalid / s_tready  | tuser kind; tdata index, resistance, lux, raw
//  m_       | out | m_tvalid / m_tready  | tuser not_found; tdata lux_fixed, resistance
//  cfg_     | in  | cfg_valid / cfg_ready| cfg_data last_index
//
// A table write leaves the block idle; a measurement holds off new items until its result
// is in the output register. The scan covers at most last_index entries, full scale skips
// the resistance divide, a negative numerator and span are both negated, and a miss ends
// after the scan. One 48-bit add/subtract unit runs the 26-step resistance divide, the scan
// compare, two 17-step shift-add products and the (43 + FRAC_BITS)-step interpolation divide.
// No clearing pass after reset; a finished result waits in the output register and
// the block stalls in its final state only if that register is still full.
module ldr_lux_table_interpolator_core #(
    parameter int TABLE_DEPTH = ldrlux_pkg::TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = ldrlux_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [8:0] entry_index, [34:9] entry_resistance, [50:35] entry_lux, [62:51] adc_raw
    input  logic [ldrlux_pkg::IN_TDATA_W-1:0]    s_tdata,
    // [0] kind
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [23:0] lux_fixed, [49:24] resistance_ohms
    output logic [ldrlux_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // [0] not_found
    output logic                                 m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ldrlux_pkg::IDX_IN_W-1:0]      cfg_data
);
    import ldrlux_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int QW    = SMAG_W + FRAC_BITS;
    localparam int CNT_W = $clog2(QW + 1);

    logic [RES_W-1:0]    res_mem [TABLE_DEPTH];
    logic [LUX_IN_W-1:0] lux_mem [TABLE_DEPTH];

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic [IDX_IN_W-1:0] last_index_reg;

    logic [RES_W-1:0]     rd_res_reg;
    logic [LUX_IN_W-1:0]  rd_lux_reg;
    logic [IDX_W-1:0]     rd_addr;

    logic [RES_W-1:0]     r_reg, r_next;
    logic [RES_W-1:0]     r0_reg, r0_next;
    logic [RES_W-1:0]     r1_reg, r1_next;
    logic [LUX_IN_W-1:0]  l0_reg, l0_next;
    logic [LUX_IN_W-1:0]  l1_reg, l1_next;
    logic [D_W-1:0]       d_reg, d_next;
    logic [D_W-1:0]       rr_reg, rr_next;
    logic [DL_W-1:0]      dl_reg, dl_next;
    logic [DL_W-1:0]      mul_reg, mul_next;
    logic [ALU_W-1:0]     mcand_reg, mcand_next;
    logic [ALU_W-1:0]     acc_reg, acc_next;
    logic [QW-1:0]        quo_reg, quo_next;
    logic [RES_W-1:0]     rem_reg, rem_next;
    logic [RES_W-1:0]     den_reg, den_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [LUX_OUT_W-1:0] lux_reg, lux_next;
    logic                 nf_reg, nf_next;
    logic [LUX_OUT_W-1:0] m_lux_reg, m_lux_next;
    logic [RES_W-1:0]     m_res_reg, m_res_next;
    logic                 m_nf_reg, m_nf_next;

    logic [ALU_W-1:0] alu_a, alu_b, alu_y;
    logic             alu_sub;

    logic [IDX_IN_W-1:0] s_entry_index;
    logic [RES_W-1:0]    s_entry_res;
    logic [LUX_IN_W-1:0] s_entry_lux;
    logic [ADC_W-1:0]    s_adc_raw;
    logic                s_accept;
    logic                wr_en;
    logic [RES_W-1:0]    rdiv_dvd;
    logic [IDX_W-1:0]    top_idx;
    logic [RES_W:0]      div_shift;
    logic                div_ok;
    logic [QW-1:0]       div_quo;
    logic [RES_W-1:0]    div_rem;
    logic                mul_last;
    logic [ALU_W-1:0]    mul_acc;

    assign s_entry_index = s_tdata[8:0];
    assign s_entry_res   = s_tdata[34:9];
    assign s_entry_lux   = s_tdata[50:35];
    assign s_adc_raw     = s_tdata[62:51];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign wr_en     = s_accept && !s_tuser && (32'(s_entry_index) < TABLE_DEPTH);
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_nf_reg;
    assign m_tdata  = {{(OUT_TDATA_W - RES_W - LUX_OUT_W){1'b0}}, m_res_reg, m_lux_reg};

    assign rdiv_dvd = RES_W'(s_adc_raw) * RES_SCALE;
    assign top_idx  = (32'(last_index_reg) > TABLE_DEPTH - 1) ?
                      IDX_W'(TABLE_DEPTH - 1) : IDX_W'(last_index_reg);

    assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);

    assign div_shift = {rem_reg, quo_reg[QW-1]};
    assign div_ok    = !alu_y[ALU_W-1];
    assign div_rem   = div_ok ? alu_y[RES_W-1:0] : div_shift[RES_W-1:0];
    assign div_quo   = {quo_reg[QW-2:0], div_ok};
    assign mul_last  = (cnt_reg == CNT_W'(1));
    assign mul_acc   = mul_reg[0] ? alu_y : acc_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            res_mem[IDX_W'(s_entry_index)] <= s_entry_res;
            lux_mem[IDX_W'(s_entry_index)] <= s_entry_lux;
        end
        rd_res_reg <= res_mem[rd_addr];
        rd_lux_reg <= lux_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            last_index_reg <= LAST_IDX_RST;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                last_index_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        r_reg     <= r_next;
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        l0_reg    <= l0_next;
        l1_reg    <= l1_next;
        d_reg     <= d_next;
        rr_reg    <= rr_next;
        dl_reg    <= dl_next;
        mul_reg   <= mul_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        lux_reg   <= lux_next;
        nf_reg    <= nf_next;
        m_lux_reg <= m_lux_next;
        m_res_reg <= m_res_next;
        m_nf_reg  <= m_nf_next;
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        r_next        = r_reg;
        r0_next       = r0_reg;
        r1_next       = r1_reg;
        l0_next       = l0_reg;
        l1_next       = l1_reg;
        d_next        = d_reg;
        rr_next       = rr_reg;
        dl_next       = dl_reg;
        mul_next      = mul_reg;
        mcand_next    = mcand_reg;
        acc_next      = acc_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        lux_next      = lux_reg;
        nf_next       = nf_reg;
        m_lux_next    = m_lux_reg;
        m_res_next    = m_res_reg;
        m_nf_next     = m_nf_reg;
        rd_addr       = idx_reg;
        alu_a         = '0;
        alu_b         = '0;
        alu_sub       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_tuser) begin
                    nf_next = 1'b0;
                    if (s_adc_raw == ADC_FULL) begin
                        r_next     = RES_MAX;
                        state_next = ST_SCAN_START;
                    end else begin
                        quo_next   = QW'(rdiv_dvd) << (QW - RES_W);
                        rem_next   = '0;
                        den_next   = RES_W'(ADC_FULL - s_adc_raw);
                        cnt_next   = CNT_W'(RES_W);
                        state_next = ST_RDIV;
                    end
                end
            end
            ST_RDIV: begin
                alu_a    = ALU_W'(div_shift);
                alu_b    = ALU_W'(den_reg);
                alu_sub  = 1'b1;
                quo_next = div_quo;
                rem_next = div_rem;
                cnt_next = cnt_reg - 1'b1;
                if (mul_last) begin
                    r_next     = div_quo[RES_W-1:0];
                    state_next = ST_SCAN_START;
                end
            end
            ST_SCAN_START: begin
                rd_addr  = top_idx;
                idx_next = top_idx;
                if (top_idx == '0) begin
                    nf_next    = 1'b1;
                    lux_next   = sat_lux(NOT_FOUND_LUX << FRAC_BITS);
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                alu_a   = ALU_W'(rd_res_reg);
                alu_b   = ALU_W'(r_reg);
                alu_sub = 1'b1;
                rd_addr = idx_reg - 1'b1;
                if (!alu_y[ALU_W-1]) begin
                    r1_next    = rd_res_reg;
                    l1_next    = rd_lux_reg;
                    state_next = ST_LOAD_LO;
                end else if (idx_reg == IDX_W'(1)) begin
                    nf_next    = 1'b1;
                    lux_next   = sat_lux(NOT_FOUND_LUX << FRAC_BITS);
                    state_next = ST_OUT;
                end else begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_LOAD_LO: begin
                alu_a      = ALU_W'(r1_reg);
                alu_b      = ALU_W'(rd_res_reg);
                alu_sub    = 1'b1;
                r0_next    = rd_res_reg;
                l0_next    = rd_lux_reg;
                d_next     = alu_y[D_W-1:0];
                state_next = ST_SUB_RR;
            end
            ST_SUB_RR: begin
                alu_a   = ALU_W'(r_reg);
                alu_b   = ALU_W'(r0_reg);
                alu_sub = 1'b1;
                rr_next = alu_y[D_W-1:0];
                if (d_reg == '0) begin
                    lux_next   = sat_lux(64'(l1_reg) << FRAC_BITS);
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SUB_L;
                end
            end
            ST_SUB_L: begin
                alu_a      = ALU_W'(l1_reg);
                alu_b      = ALU_W'(l0_reg);
                alu_sub    = 1'b1;
                dl_next    = alu_y[DL_W-1:0];
                mcand_next = {{(ALU_W - D_W){d_reg[D_W-1]}}, d_reg};
                mul_next   = {1'b0, l0_reg};
                acc_next   = '0;
                cnt_next   = CNT_W'(MUL_STEPS);
                state_next = ST_MUL_A;
            end
            ST_MUL_A: begin
                alu_a      = acc_reg;
                alu_b      = mcand_reg;
                alu_sub    = mul_last;
                acc_next   = mul_acc;
                mcand_next = mcand_reg << 1;
                mul_next   = mul_reg >> 1;
                cnt_next   = cnt_reg - 1'b1;
                if (mul_last) begin
                    mcand_next = {{(ALU_W - D_W){rr_reg[D_W-1]}}, rr_reg};
                    mul_next   = dl_reg;
                    cnt_next   = CNT_W'(MUL_STEPS);
                    state_next = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                alu_a      = acc_reg;
                alu_b      = mcand_reg;
                alu_sub    = mul_last;
                acc_next   = mul_acc;
                mcand_next = mcand_reg << 1;
                mul_next   = mul_reg >> 1;
                cnt_next   = cnt_reg - 1'b1;
                if (mul_last) begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN: begin
                if (acc_reg == '0 || (acc_reg[ALU_W-1] != d_reg[D_W-1])) begin
                    lux_next   = '0;
                    state_next = ST_OUT;
                end else if (acc_reg[ALU_W-1]) begin
                    state_next = ST_NEG_S;
                end else begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_NEG_S: begin
                alu_b      = acc_reg;
                alu_sub    = 1'b1;
                acc_next   = alu_y;
                state_next = ST_NEG_D;
            end
            ST_NEG_D: begin
                alu_b      = {{(ALU_W - D_W){d_reg[D_W-1]}}, d_reg};
                alu_sub    = 1'b1;
                d_next     = alu_y[D_W-1:0];
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                quo_next   = QW'(acc_reg[SMAG_W-1:0]) << FRAC_BITS;
                rem_next   = '0;
                den_next   = d_reg[RES_W-1:0];
                cnt_next   = CNT_W'(QW);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                alu_a    = ALU_W'(div_shift);
                alu_b    = ALU_W'(den_reg);
                alu_sub  = 1'b1;
                quo_next = div_quo;
                rem_next = div_rem;
                cnt_next = cnt_reg - 1'b1;
                if (mul_last) begin
                    lux_next   = sat_lux(64'(div_quo));
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_lux_next    = lux_reg;
                    m_res_next    = r_reg;
                    m_nf_next     = nf_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_div_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RDIV || state_reg == ST_DIV) |-> (rem_reg < den_reg))
        else $error("division remainder not below divisor");

    a_scan_idx_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (idx_reg != '0) && (idx_reg <= top_idx))
        else $error("scan index out of range");

    a_out_holds_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_tvalid_reg && !m_tready) |=> (state_reg == ST_OUT))
        else $error("result overwrote a pending transfer");

    a_not_found_lux: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (m_tdata[LUX_OUT_W-1:0] == sat_lux(NOT_FOUND_LUX << FRAC_BITS)))
        else $error("not-found result carries wrong lux");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the LDR lux table interpolator: table loads, scans, handshakes.
`timescale 1ns / 100ps

module tb_top;
    import ldrlux_pkg::*;

    localparam int     DEPTH          = TABLE_DEPTH_DEF;
    localparam int     FRAC           = FRAC_BITS_DEF;
    localparam longint LUX_ONE        = longint'(1) << FRAC;
    localparam logic   KIND_WRITE     = 1'b0;
    localparam logic   KIND_MEASURE   = 1'b1;
    localparam int     SETTLE_CYCLES  = 800;
    localparam int     HOLD_CYCLES    = 4000;
    localparam int     WATCHDOG_LIMIT = 20000;
    localparam int     IDLE_PCT       = 20;

    typedef struct packed {
        logic [ADC_W-1:0]    raw;
        logic [LUX_IN_W-1:0] lux;
        logic [RES_W-1:0]    ohms;
        logic [IDX_IN_W-1:0] idx;
    } entry_fields_t;

    typedef struct {
        logic          kind;
        entry_fields_t f;
    } sensor_item_t;

    typedef struct packed {
        logic [LUX_OUT_W-1:0] lux;
        logic                 miss;
        logic [RES_W-1:0]     ohms;
    } lux_reading_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IDX_IN_W-1:0]    cfg_data  = '0;

    logic [RES_W-1:0]    ohm_table [DEPTH];
    logic [LUX_IN_W-1:0] lux_table [DEPTH];
    logic [IDX_IN_W-1:0] scan_top = LAST_IDX_RST;

    sensor_item_t sensor_items [$];
    lux_reading_t pending_readings [$];
    sensor_item_t cur_item;

    int  n_pushed = 0, n_accepted = 0, n_writes = 0, n_measures = 0;
    int  n_results = 0, n_miss = 0, n_edge = 0, n_settings = 1, n_errors = 0;
    int  stall_req = 0, stall_seen = 0, hold_left = 0, quiet_cycles = 0;
    bit  steady = 1'b0;

    ldr_lux_table_interpolator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [RES_W-1:0] divider_ohms(input logic [ADC_W-1:0] raw);
        if (raw == ADC_FULL) begin
            return RES_MAX;
        end
        return RES_W'((longint'(RES_SCALE) * longint'(raw)) / (longint'(ADC_FULL) - longint'(raw)));
    endfunction

    function automatic lux_reading_t predict_reading(input logic [ADC_W-1:0] raw);
        lux_reading_t rd;
        longint       r, r0, r1, l0, l1, d, q;
        int           i;
        bit           hit;
        rd.ohms = divider_ohms(raw);
        r       = longint'(rd.ohms);
        q       = longint'(NOT_FOUND_LUX) * LUX_ONE;
        hit     = 1'b0;
        for (i = int'(scan_top); i > 0 && !hit; i--) begin
            if (longint'(ohm_table[i]) >= r) begin
                r1 = longint'(ohm_table[i]);
                r0 = longint'(ohm_table[i-1]);
                l1 = longint'(lux_table[i]);
                l0 = longint'(lux_table[i-1]);
                d  = r1 - r0;
                if (d == 0) begin
                    q = l1 * LUX_ONE;
                end else begin
                    q = (l0 * d * LUX_ONE + (r - r0) * (l1 - l0) * LUX_ONE) / d;
                end
                hit = 1'b1;
            end
        end
        rd.miss = !hit;
        if (q < 0) begin
            rd.lux = '0;
        end else if (q > longint'(LUX_MAX)) begin
            rd.lux = LUX_MAX;
        end else begin
            rd.lux = LUX_OUT_W'(q);
        end
        return rd;
    endfunction

    task automatic apply_item(input sensor_item_t it);
        lux_reading_t rd;
        if (it.kind == KIND_WRITE) begin
            ohm_table[it.f.idx] = it.f.ohms;
            lux_table[it.f.idx] = it.f.lux;
            n_writes++;
        end else begin
            rd = predict_reading(it.f.raw);
            pending_readings.push_back(rd);
            n_measures++;
            if (rd.miss) n_miss++;
            if (rd.lux == '0 || rd.lux == LUX_MAX) n_edge++;
        end
    endtask

    function automatic void note_error(input string msg);
        n_errors++;
        if (n_errors <= 10) $display("%s", msg);
    endfunction

    task automatic check_reading;
        lux_reading_t want;
        lux_reading_t got;
        got.lux  = m_tdata[LUX_OUT_W-1:0];
        got.ohms = m_tdata[LUX_OUT_W+RES_W-1:LUX_OUT_W];
        got.miss = m_tuser;
        if (pending_readings.size() == 0) begin
            note_error($sformatf("unexpected result: lux %h miss %b ohms %0d",
                                 got.lux, got.miss, got.ohms));
        end else begin
            want = pending_readings.pop_front();
            n_results++;
            if (got.lux !== want.lux || got.miss !== want.miss || got.ohms !== want.ohms) begin
                note_error($sformatf(
                    "result %0d mismatch: expected lux %h miss %b ohms %0d, got lux %h miss %b ohms %0d",
                    n_results, want.lux, want.miss, want.ohms, got.lux, got.miss, got.ohms));
            end
        end
    endtask

    // Input side: present queued items, mirror each write and predict each measurement on its transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_item(cur_item);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (sensor_items.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_item = sensor_items.pop_front();
                    s_tuser  <= cur_item.kind;
                    s_tdata  <= {1'b0, cur_item.f};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each transfer, hold off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_reading();
            if (stall_req != stall_seen) begin
                stall_seen = stall_req;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_readings.size());
            $display("FAIL ldr_lux_table_interpolator_core");
            $finish;
        end
    end

    function automatic logic [RES_W-1:0] curve_ohms(input int k);
        if (k == 0) return RES_MAX;
        if (k == DEPTH - 1) return '0;
        return divider_ohms(ADC_W'(4095 - 8 * k));
    endfunction

    function automatic logic [LUX_IN_W-1:0] curve_lux(input int k);
        if (k == DEPTH - 1) return '1;
        return LUX_IN_W'(k * 128);
    endfunction

    function automatic entry_fields_t noise_fields;
        entry_fields_t f;
        f.idx  = IDX_IN_W'($urandom());
        f.ohms = RES_W'($urandom());
        f.lux  = LUX_IN_W'($urandom());
        f.raw  = ADC_W'($urandom());
        return f;
    endfunction

    task automatic push_write(input int idx, input logic [RES_W-1:0] ohms,
                              input logic [LUX_IN_W-1:0] lux);
        sensor_item_t it;
        it.kind   = KIND_WRITE;
        it.f      = noise_fields();
        it.f.idx  = IDX_IN_W'(idx);
        it.f.ohms = ohms;
        it.f.lux  = lux;
        sensor_items.push_back(it);
        n_pushed++;
    endtask

    task automatic push_measure(input int raw);
        sensor_item_t it;
        it.kind  = KIND_MEASURE;
        it.f     = noise_fields();
        it.f.raw = ADC_W'(raw);
        sensor_items.push_back(it);
        n_pushed++;
    endtask

    function automatic int pick_raw;
        int p;
        p = $urandom_range(0, 99);
        if (p < 80) return $urandom_range(0, 4095);
        if (p < 90) return 4095 - 8 * $urandom_range(1, DEPTH - 1);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 1;
            2: return 4094;
            default: return 4095;
        endcase
    endfunction

    task automatic push_random(input int count);
        int k, p, idx;
        for (k = 0; k < count; k++) begin
            p   = $urandom_range(0, 99);
            idx = $urandom_range(0, DEPTH - 1);
            if (p < 50) begin
                push_measure(pick_raw());
            end else if (p < 75) begin
                push_write(idx, curve_ohms(idx) ^ RES_W'($urandom_range(0, 15)),
                           curve_lux(idx) ^ LUX_IN_W'($urandom_range(0, 63)));
            end else if (p < 92) begin
                push_write(idx, RES_W'($urandom_range(0, RES_MAX)), LUX_IN_W'($urandom()));
            end else begin
                push_write(idx, $urandom_range(0, 1) ? RES_MAX : '0,
                           $urandom_range(0, 1) ? '1 : '0);
            end
        end
    endtask

    task automatic drain;
        while (n_accepted != n_pushed || pending_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_scan_top(input int top);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= IDX_IN_W'(top);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        scan_top = IDX_IN_W'(top);
        n_settings++;
    endtask

    initial begin
        int k;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < DEPTH; k++) push_write(k, curve_ohms(k), curve_lux(k));
        push_measure(0);
        push_measure(4095);
        push_measure(4094);
        push_measure(1);
        push_measure(2047);
        push_measure(2048);
        push_measure(4095 - 8 * 200);
        push_write(300, curve_ohms(299), curve_lux(300));
        push_measure(4095 - 8 * 299);
        push_write(100, curve_ohms(100), '0);
        push_write(99, curve_ohms(99), '1);
        push_measure(3291);
        push_write(451, curve_ohms(451), '0);
        push_write(452, curve_ohms(452), '1);
        push_measure(0);
        push_random(80);
        drain();

        set_scan_top(DEPTH - 1);
        for (k = 0; k < 12; k++) push_measure(pick_raw());
        stall_req++;
        push_random(80);
        drain();

        steady = 1'b1;
        set_scan_top(1);
        push_random(60);
        drain();
        set_scan_top(2);
        push_random(40);
        drain();
        steady = 1'b0;

        set_scan_top($urandom_range(3, 40));
        push_random(120);
        drain();

        set_scan_top(256);
        push_random(40);
        drain();

        set_scan_top($urandom_range(1, 63));
        push_random(80);
        drain();

        $display("Ran %0d table writes and %0d measurements over %0d scan depths;",
                 n_writes, n_measures, n_settings);
        $display("%0d results checked, %0d not found, %0d at a lux limit, %0d errors.",
                 n_results, n_miss, n_edge, n_errors);
        if (n_errors == 0) begin
            $display("PASS ldr_lux_table_interpolator_core");
        end else begin
            $display("FAIL ldr_lux_table_interpolator_core");
        end
        $finish;
    end

endmodule
